### design/mi3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_pkg
// Types and constants shared by the 3x3 matrix inverse / adjugate block.
// ----------------------------------------------------------------------------
package mi3_pkg;

    localparam int N_ENT     = 9;
    localparam int A_W       = 16;                 // Q4.12 input entry
    localparam int P_W       = 2 * A_W;            // 2x2 product
    localparam int COF_W     = P_W + 1;            // exact cofactor, Q9.24
    localparam int DP_W      = A_W + COF_W;        // determinant partial product
    localparam int DET_W     = DP_W + 2;           // exact determinant, Q15.36
    localparam int UD_W      = DET_W - 1;          // determinant magnitude
    localparam int RES_W     = 32;                 // result entry, Q8.24
    localparam int DETO_W    = 48;                 // determinant port width
    localparam int NUM_W     = 32;                 // cofactor magnitude
    localparam int FRAC_BITS = 36;
    localparam int DIV_STEPS = NUM_W + FRAC_BITS;  // one quotient bit per stage
    localparam int DIV_LAT   = DIV_STEPS + 2;      // prepare + steps + round
    localparam int COF_LAT   = 4;

    typedef logic signed [A_W-1:0]   t_ent;
    typedef t_ent [N_ENT-1:0]        t_ent_vec;
    typedef logic signed [COF_W-1:0] t_cof;
    typedef t_cof [N_ENT-1:0]        t_cof_vec;
    typedef logic signed [DET_W-1:0] t_det;
    typedef logic signed [RES_W-1:0] t_res;
    typedef t_res [N_ENT-1:0]        t_res_vec;
    typedef logic [3:0]              t_idx;

    // Cofactor k = a[P]*a[Q] - a[S]*a[T], entries indexed 3*row+col
    localparam t_idx COF_P [N_ENT] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
    localparam t_idx COF_Q [N_ENT] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
    localparam t_idx COF_S [N_ENT] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
    localparam t_idx COF_T [N_ENT] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

    typedef struct packed {
        logic mode;
        t_ent a_r0c0;
        t_ent a_r0c1;
        t_ent a_r0c2;
        t_ent a_r1c0;
        t_ent a_r1c1;
        t_ent a_r1c2;
        t_ent a_r2c0;
        t_ent a_r2c1;
        t_ent a_r2c2;
    } t_mi3_in;

    typedef struct packed {
        t_res                     b_r0c0;
        t_res                     b_r0c1;
        t_res                     b_r0c2;
        t_res                     b_r1c0;
        t_res                     b_r1c1;
        t_res                     b_r1c2;
        t_res                     b_r2c0;
        t_res                     b_r2c1;
        t_res                     b_r2c2;
        logic signed [DETO_W-1:0] det_value;
        logic                     singular;
        logic                     saturated;
    } t_mi3_out;

    // One stage of the restoring divider lane
    typedef struct packed {
        logic [UD_W-1:0]  rem;
        logic [NUM_W-1:0] quo;
        logic             big;
        logic [NUM_W-1:0] num;
        logic [UD_W-1:0]  ud;
        logic             neg;
        logic             mode;
        logic             sing;
        t_res             adj_clip;
        logic             adj_sat;
    } t_div_stage;

endpackage

### design/mi3_cofactor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_cofactor
// Four-stage pipeline: 2x2 products, cofactors, determinant products, sum.
// ----------------------------------------------------------------------------
module mi3_cofactor
    import mi3_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_en,
    input  logic     i_mode,
    input  t_ent_vec i_a,
    output logic     o_mode,
    output t_cof_vec o_adj,
    output t_det     o_det
);

    logic signed [P_W-1:0]  r_pp [N_ENT];
    logic signed [P_W-1:0]  r_pq [N_ENT];
    t_ent                   r_row0_1 [3];
    t_ent                   r_row0_2 [3];
    logic                   r_mode1, r_mode2, r_mode3, r_mode4;
    t_cof_vec               r_adj2, r_adj3, r_adj4;
    logic signed [DP_W-1:0] r_dp [3];
    t_det                   r_det;

    // Form products, cofactors, then the first-row expansion
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < N_ENT; k++) begin
                r_pp[k]   <= i_a[COF_P[k]] * i_a[COF_Q[k]];
                r_pq[k]   <= i_a[COF_S[k]] * i_a[COF_T[k]];
                r_adj2[k] <= COF_W'(r_pp[k]) - COF_W'(r_pq[k]);
            end
            for (int j = 0; j < 3; j++) begin
                r_row0_1[j] <= i_a[j];
                r_row0_2[j] <= r_row0_1[j];
                r_dp[j]     <= DP_W'(r_row0_2[j]) * DP_W'(r_adj2[3*j]);
            end
            r_det   <= DET_W'(r_dp[0]) + DET_W'(r_dp[1]) + DET_W'(r_dp[2]);
            r_adj3  <= r_adj2;
            r_adj4  <= r_adj3;
            r_mode1 <= i_mode;
            r_mode2 <= r_mode1;
            r_mode3 <= r_mode2;
            r_mode4 <= r_mode3;
        end
    end

    assign o_mode = r_mode4;
    assign o_adj  = r_adj4;
    assign o_det  = r_det;

endmodule

### design/mi3_div_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_div_lane
// One result entry: pipelined restoring divide of cofactor * 2^36 by the
// determinant, one quotient bit per stage, round half away, saturate.
// ----------------------------------------------------------------------------
module mi3_div_lane
    import mi3_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  logic i_mode,
    input  t_cof i_adj,
    input  t_det i_det,
    output t_res o_entry,
    output logic o_sat
);

    t_div_stage       r_st [DIV_STEPS+1];
    t_div_stage       n_st0;
    logic [COF_W-1:0] adj_abs;
    logic [DET_W-1:0] det_abs;

    // Prepare magnitudes, sign and the clipped adjugate
    always_comb begin
        adj_abs        = i_adj[COF_W-1] ? COF_W'(-i_adj) : COF_W'(i_adj);
        det_abs        = i_det[DET_W-1] ? DET_W'(-i_det) : DET_W'(i_det);
        n_st0          = '0;
        n_st0.num      = adj_abs[NUM_W-1:0];
        n_st0.ud       = det_abs[UD_W-1:0];
        n_st0.neg      = i_adj[COF_W-1] ^ i_det[DET_W-1];
        n_st0.mode     = i_mode;
        n_st0.sing     = (i_det == '0);
        n_st0.adj_sat  = i_adj[COF_W-1] ^ i_adj[COF_W-2];
        if (n_st0.adj_sat) begin
            n_st0.adj_clip = i_adj[COF_W-1] ? {1'b1, {(RES_W-1){1'b0}}}
                                            : {1'b0, {(RES_W-1){1'b1}}};
        end else begin
            n_st0.adj_clip = i_adj[RES_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= n_st0;
        end
    end

    // Divider stages
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [UD_W:0] shifted;
        logic          ge;
        t_div_stage    n_st;

        always_comb begin
            n_st    = r_st[k];
            shifted = {r_st[k].rem, r_st[k].num[NUM_W-1]};
            ge      = (shifted >= {1'b0, r_st[k].ud});
            n_st.rem = ge ? UD_W'(shifted - {1'b0, r_st[k].ud}) : shifted[UD_W-1:0];
            n_st.big = r_st[k].big | r_st[k].quo[NUM_W-1];
            n_st.quo = {r_st[k].quo[NUM_W-2:0], ge};
            n_st.num = {r_st[k].num[NUM_W-2:0], 1'b0};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k+1] <= n_st;
            end
        end
    end

    // Round, saturate and pick the result for the mode
    t_div_stage       last;
    logic             rnd;
    logic [NUM_W:0]   rounded;
    logic [NUM_W:0]   lim;
    logic             dsat;
    logic [RES_W-1:0] mag;
    t_res             n_entry;
    logic             n_sat;
    t_res             r_entry;
    logic             r_sat;

    always_comb begin
        last    = r_st[DIV_STEPS];
        rnd     = ({last.rem, 1'b0} >= {1'b0, last.ud});
        rounded = {1'b0, last.quo} + (NUM_W+1)'(rnd);
        lim     = last.neg ? {2'b01, {(NUM_W-1){1'b0}}} : {2'b00, {(NUM_W-1){1'b1}}};
        dsat    = last.big || (rounded > lim);
        mag     = dsat ? lim[RES_W-1:0] : rounded[RES_W-1:0];
        if (last.mode) begin
            n_entry = last.adj_clip;
            n_sat   = last.adj_sat;
        end else if (last.sing) begin
            n_entry = '0;
            n_sat   = 1'b0;
        end else begin
            n_entry = last.neg ? -mag : mag;
            n_sat   = dsat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_entry <= n_entry;
            r_sat   <= n_sat;
        end
    end

    assign o_entry = r_entry;
    assign o_sat   = r_sat;

endmodule

### design/mi3_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_merge
// Combine the lane results with the determinant, then output register
// and skid stage that decouple the pipeline from the receiver.
// ----------------------------------------------------------------------------
module mi3_merge
    import mi3_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_res_vec i_entries,
    input  logic [N_ENT-1:0] i_sats,
    input  t_det     i_det,
    output logic     o_en,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_mi3_out o_out_data
);

    t_mi3_out n_item;
    logic     det_sat;
    t_mi3_out r_out, r_skid;
    logic     r_out_v, r_skid_v;

    // Merge lanes, clip determinant, gather flags
    always_comb begin
        det_sat = (i_det[DET_W-1:DETO_W-1] != '0) && (i_det[DET_W-1:DETO_W-1] != '1);
        n_item.b_r0c0 = i_entries[0];
        n_item.b_r0c1 = i_entries[1];
        n_item.b_r0c2 = i_entries[2];
        n_item.b_r1c0 = i_entries[3];
        n_item.b_r1c1 = i_entries[4];
        n_item.b_r1c2 = i_entries[5];
        n_item.b_r2c0 = i_entries[6];
        n_item.b_r2c1 = i_entries[7];
        n_item.b_r2c2 = i_entries[8];
        if (det_sat) begin
            n_item.det_value = i_det[DET_W-1] ? {1'b1, {(DETO_W-1){1'b0}}}
                                              : {1'b0, {(DETO_W-1){1'b1}}};
        end else begin
            n_item.det_value = i_det[DETO_W-1:0];
        end
        n_item.singular  = (i_det == '0);
        n_item.saturated = (|i_sats) | det_sat;
    end

    // Hold the pipeline only while the skid stage is occupied
    assign o_en = !r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (i_out_ready) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (!r_out_v || i_out_ready) begin
            r_out_v <= i_valid;
        end else if (i_valid) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (i_out_ready) begin
                r_out <= r_skid;
            end
        end else if (!r_out_v || i_out_ready) begin
            r_out <= n_item;
        end else begin
            r_skid <= n_item;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule

### design/matrix_inverse_3x3_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_top
// 3x3 adjugate / inverse with exact determinant, fully pipelined.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready / i_in_data) carries one matrix per
// item: nine signed Q4.12 entries and a mode bit (0 inverse, 1 adjugate).
// Output channel (o_out_valid / i_out_ready / o_out_data) returns one item
// per input item, in order: nine Q8.24 entries, Q12.36 determinant, the
// singular and saturated flags.
// Data pass the cofactor and determinant stages, then the divider lanes
// (one quotient bit per stage over 68 stages, plus prepare and round), then
// the output register. Throughput is one item per cycle while the skid stage
// is empty; nine divider lanes run side by side, one per result entry.
// When the receiver stalls, a skid stage catches one item and then the whole
// pipeline holds; o_in_ready drops only while the skid stage is full.
// Reset clears the valid bits of the pipeline, output and skid stage; the
// block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3_top
    import mi3_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_mi3_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_mi3_out o_out_data
);

    localparam int PIPE_LAT = COF_LAT + DIV_LAT;

    logic             en;
    t_ent_vec         a_vec;
    logic             cof_mode;
    t_cof_vec         cof_adj;
    t_det             cof_det;
    t_res_vec         lane_entry;
    logic [N_ENT-1:0] lane_sat;
    logic             r_vld [PIPE_LAT];
    t_det             r_det [DIV_LAT];

    assign a_vec = {i_in_data.a_r2c2, i_in_data.a_r2c1, i_in_data.a_r2c0,
                    i_in_data.a_r1c2, i_in_data.a_r1c1, i_in_data.a_r1c0,
                    i_in_data.a_r0c2, i_in_data.a_r0c1, i_in_data.a_r0c0};

    assign o_in_ready = en;

    mi3_cofactor u_cof (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_mode (i_in_data.mode),
        .i_a    (a_vec),
        .o_mode (cof_mode),
        .o_adj  (cof_adj),
        .o_det  (cof_det)
    );

    // One divider lane per result entry
    for (genvar k = 0; k < N_ENT; k++) begin : g_lane
        mi3_div_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_mode  (cof_mode),
            .i_adj   (cof_adj[k]),
            .i_det   (cof_det),
            .o_entry (lane_entry[k]),
            .o_sat   (lane_sat[k])
        );
    end

    // Advance valid bits alongside the data path
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < PIPE_LAT; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_in_valid;
            for (int s = 1; s < PIPE_LAT; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // Carry the determinant past the divider lanes
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_det[0] <= cof_det;
            for (int s = 1; s < DIV_LAT; s++) begin
                r_det[s] <= r_det[s-1];
            end
        end
    end

    mi3_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_vld[PIPE_LAT-1]),
        .i_entries   (lane_entry),
        .i_sats      (lane_sat),
        .i_det       (r_det[DIV_LAT-1]),
        .o_en        (en),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

### design/mi3_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_checker
// Port-level checks of the 3x3 inverse block, bound to the top level.
// ----------------------------------------------------------------------------
module mi3_checker
    import mi3_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_ready,
    input t_mi3_in  i_in_data,
    input logic     o_out_valid,
    input logic     i_out_ready,
    input t_mi3_out o_out_data
);

    // Waiting input item stays presented
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("input item changed while waiting");

    // Stalled item stays presented
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("output item changed while stalled");

    // Singular flag agrees with the determinant
    a_singular: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.singular == (o_out_data.det_value == '0)))
        else $error("singular flag disagrees with determinant");

    // Reset empties the output and skid stages
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not empty after reset");

endmodule

bind matrix_inverse_3x3_top mi3_checker u_mi3_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
